// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CFT_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define CFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ----- hw/rtl/cft_pkg.sv -----
package cft_pkg;

    localparam int BYTE_W   = 8;
    localparam int VALUE_W  = 63;
    localparam int LEN_W    = 11;
    localparam int COL_W    = 8;
    localparam int ROW_W    = 16;
    localparam int WIDE_W   = 9;
    localparam int DOTS_W   = 2;

    // Delimiters and character classes
    localparam logic [BYTE_W-1:0] CH_COMMA   = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_DOT     = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;

    // Largest value, and that value divided by ten (remainder seven)
    localparam logic [VALUE_W-1:0] VALUE_MAX   = {VALUE_W{1'b1}};
    localparam logic [VALUE_W-1:0] VALUE_DIV10 = 63'd922337203685477580;

    localparam logic [DOTS_W-1:0] DOTS_ONE = 2'd1;
    localparam logic [DOTS_W-1:0] DOTS_TWO = 2'd2;

    typedef enum logic [1:0] {
        KIND_EMPTY  = 2'd0,
        KIND_INT    = 2'd1,
        KIND_FLOAT  = 2'd2,
        KIND_STRING = 2'd3
    } field_kind_t;

    // Per-item control from the input stage to the state holders
    typedef struct packed {
        logic take;
        logic close;
        logic row_end;
    } step_t;

    typedef struct packed {
        field_kind_t        kind;
        logic [VALUE_W-1:0] acc;
        logic               clamp;
        logic [LEN_W-1:0]   frac;
        logic [LEN_W-1:0]   bytes;
    } field_state_t;

    typedef struct packed {
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
        logic [WIDE_W-1:0] widest_after;
    } pos_state_t;

    typedef struct packed {
        field_kind_t        field_kind;
        logic [VALUE_W-1:0] digit_value;
        logic [LEN_W-1:0]   scale_digits;
        logic               value_saturated;
        logic [LEN_W-1:0]   field_length;
        logic [COL_W-1:0]   column_index;
        logic [ROW_W-1:0]   row_index;
        logic               ends_row;
        logic [WIDE_W-1:0]  widest_row;
    } result_t;

endpackage

// ----- hw/rtl/cft_ifs.sv -----
interface cft_in_if import cft_pkg::*;
    ;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] text_byte;
    logic              end_of_input;

    modport source (output valid, text_byte, end_of_input, input ready);
    modport sink   (input valid, text_byte, end_of_input, output ready);
endinterface

interface cft_out_if import cft_pkg::*;
    ;
    logic               valid;
    logic               ready;
    logic [1:0]         field_kind;
    logic [VALUE_W-1:0] digit_value;
    logic [LEN_W-1:0]   scale_digits;
    logic               value_saturated;
    logic [LEN_W-1:0]   field_length;
    logic [COL_W-1:0]   column_index;
    logic [ROW_W-1:0]   row_index;
    logic               ends_row;
    logic [WIDE_W-1:0]  widest_row;

    modport source (output valid, field_kind, digit_value, scale_digits, value_saturated,
                    field_length, column_index, row_index, ends_row, widest_row,
                    input ready);
    modport sink   (input valid, field_kind, digit_value, scale_digits, value_saturated,
                    field_length, column_index, row_index, ends_row, widest_row,
                    output ready);
endinterface

// ----- hw/rtl/cft_field.sv -----
module cft_field import cft_pkg::*;
#(
    parameter int MAX_FIELD_BYTES = 1024
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  step_t             step,
    input  logic [BYTE_W-1:0] text_byte,
    output field_state_t      fs
);

    localparam int LenCapInt = (MAX_FIELD_BYTES < 2047) ? MAX_FIELD_BYTES : 2047;
    localparam logic [LEN_W-1:0] LenCap = LEN_W'(LenCapInt);

    field_kind_t        kind_reg,  kind_next;
    logic [VALUE_W-1:0] acc_reg,   acc_next;
    logic               clamp_reg, clamp_next;
    logic [DOTS_W-1:0]  dots_reg,  dots_next;
    logic [LEN_W-1:0]   frac_reg,  frac_next;
    logic [LEN_W-1:0]   bytes_reg, bytes_next;

    logic               is_digit;
    logic               is_dot;
    logic [VALUE_W-1:0] digit;
    logic [VALUE_W-1:0] limit;
    logic [VALUE_W-1:0] acc_x10;

    // Classify the byte and form the times-ten accumulate by shifts
    always_comb
    begin
        is_digit = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
        is_dot   = (text_byte == CH_DOT);
        digit    = VALUE_W'(text_byte - CH_ZERO) & VALUE_W'(4'hF);
        limit    = (digit > VALUE_W'(7)) ? (VALUE_DIV10 - VALUE_W'(1)) : VALUE_DIV10;
        acc_x10  = {acc_reg[VALUE_W-4:0], 3'b000} + {acc_reg[VALUE_W-2:0], 1'b0} + digit;
    end

    // Fold one byte into the field state
    always_comb
    begin
        kind_next  = kind_reg;
        acc_next   = acc_reg;
        clamp_next = clamp_reg;
        dots_next  = dots_reg;
        frac_next  = frac_reg;
        bytes_next = bytes_reg;
        if (step.close)
        begin
            kind_next  = KIND_EMPTY;
            acc_next   = '0;
            clamp_next = 1'b0;
            dots_next  = '0;
            frac_next  = '0;
            bytes_next = '0;
        end
        else if (step.take)
        begin
            if (bytes_reg < LenCap)
            begin
                bytes_next = bytes_reg + LEN_W'(1);
            end
            if (is_digit)
            begin
                if (kind_reg == KIND_EMPTY)
                begin
                    kind_next = KIND_INT;
                end
                if (dots_reg < DOTS_TWO)
                begin
                    if (acc_reg > limit)
                    begin
                        acc_next   = VALUE_MAX;
                        clamp_next = 1'b1;
                    end
                    else
                    begin
                        acc_next = acc_x10;
                    end
                    if (dots_reg == DOTS_ONE && frac_reg < LenCap)
                    begin
                        frac_next = frac_reg + LEN_W'(1);
                    end
                end
            end
            else if (is_dot)
            begin
                if (kind_reg != KIND_STRING)
                begin
                    kind_next = KIND_FLOAT;
                end
                if (dots_reg < DOTS_TWO)
                begin
                    dots_next = dots_reg + DOTS_W'(1);
                end
            end
            else
            begin
                kind_next = KIND_STRING;
            end
        end
    end

    // Hold the field state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg  <= KIND_EMPTY;
            acc_reg   <= '0;
            clamp_reg <= 1'b0;
            dots_reg  <= '0;
            frac_reg  <= '0;
            bytes_reg <= '0;
        end
        else
        begin
            kind_reg  <= kind_next;
            acc_reg   <= acc_next;
            clamp_reg <= clamp_next;
            dots_reg  <= dots_next;
            frac_reg  <= frac_next;
            bytes_reg <= bytes_next;
        end
    end

    assign fs.kind  = kind_reg;
    assign fs.acc   = acc_reg;
    assign fs.clamp = clamp_reg;
    assign fs.frac  = frac_reg;
    assign fs.bytes = bytes_reg;

endmodule

// ----- hw/rtl/cft_pos.sv -----
module cft_pos import cft_pkg::*;
#(
    parameter int MAX_COLUMNS = 256,
    parameter int MAX_ROWS    = 65536
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  step_t      step,
    output pos_state_t pos
);

    localparam int ColCapInt  = (MAX_COLUMNS - 1 < 255) ? MAX_COLUMNS - 1 : 255;
    localparam int WideCapInt = (MAX_COLUMNS < 511) ? MAX_COLUMNS : 511;
    localparam int RowCapInt  = (MAX_ROWS - 1 < 65535) ? MAX_ROWS - 1 : 65535;
    localparam logic [COL_W-1:0]  ColCap  = COL_W'(ColCapInt);
    localparam logic [WIDE_W-1:0] WideCap = WIDE_W'(WideCapInt);
    localparam logic [ROW_W-1:0]  RowCap  = ROW_W'(RowCapInt);

    logic [COL_W-1:0]  column_reg, column_next;
    logic [ROW_W-1:0]  row_reg,    row_next;
    logic [WIDE_W-1:0] widest_reg, widest_next;
    logic [WIDE_W-1:0] cols;
    logic [WIDE_W-1:0] widest_after;

    // Count columns of the row this field ends, and track the widest
    always_comb
    begin
        cols = {1'b0, column_reg} + WIDE_W'(1);
        if (cols > WideCap)
        begin
            cols = WideCap;
        end
        widest_after = widest_reg;
        if (step.row_end && cols > widest_reg)
        begin
            widest_after = cols;
        end
    end

    // Advance column or row when a field closes
    always_comb
    begin
        column_next = column_reg;
        row_next    = row_reg;
        widest_next = widest_reg;
        if (step.close)
        begin
            widest_next = widest_after;
            if (step.row_end)
            begin
                column_next = '0;
                if (row_reg < RowCap)
                begin
                    row_next = row_reg + ROW_W'(1);
                end
            end
            else if (column_reg < ColCap)
            begin
                column_next = column_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            row_reg    <= '0;
            widest_reg <= '0;
        end
        else
        begin
            column_reg <= column_next;
            row_reg    <= row_next;
            widest_reg <= widest_next;
        end
    end

    assign pos.column       = column_reg;
    assign pos.row          = row_reg;
    assign pos.widest_after = widest_after;

endmodule

// ----- hw/rtl/csv_field_typing_tokenizer.sv -----
// CSV field tokenizer: takes one text byte per item and, when a comma, a newline or an
// end-of-input item closes a field, returns one result with the field's type (empty,
// integer, float, string), its decimal digit value (clamped, with a flag), the count of
// digits after the first dot, its length, column, row, a row-end mark and the widest
// completed row. End of input on an empty row gives no result. Sustained rate is one
// item per cycle while the held result is not stalled; an accepted item is held in the
// input stage register, and the result is registered when the closing item leaves it. The
// cycle is set by the 63-bit times-ten accumulate and its overflow compare in the
// field unit. No clearing pass is needed after reset.
module csv_field_typing_tokenizer import cft_pkg::*;
#(
    parameter int MAX_FIELD_BYTES = 1024,
    parameter int MAX_COLUMNS     = 256,
    parameter int MAX_ROWS        = 65536
)
(
    input  logic      clk,
    input  logic      rst_n,
    cft_in_if.sink    text_in,
    cft_out_if.source field_out
);

    logic              s1_valid_reg, s1_valid_next;
    logic [BYTE_W-1:0] s1_byte_reg;
    logic              s1_eoi_reg;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg;

    logic         accept;
    logic         out_busy;
    logic         s1_go;
    logic         is_comma;
    logic         is_newline;
    logic         row_open;
    logic         numeric;
    step_t        step;
    field_state_t fs;
    pos_state_t   pos;
    result_t      result;

    // Handshake: the input stage moves whenever the result register can take
    assign out_busy      = out_valid_reg && !field_out.ready;
    assign s1_go         = s1_valid_reg && !out_busy;
    assign text_in.ready = !s1_valid_reg || !out_busy;
    assign accept        = text_in.valid && text_in.ready;

    // Decode the held item into a step
    always_comb
    begin
        is_comma     = (s1_byte_reg == CH_COMMA);
        is_newline   = (s1_byte_reg == CH_NEWLINE);
        row_open     = (fs.bytes != '0) || (pos.column != '0);
        step.close   = s1_go && (s1_eoi_reg ? row_open : (is_comma || is_newline));
        step.row_end = s1_eoi_reg || is_newline;
        step.take    = s1_go && !s1_eoi_reg && !is_comma && !is_newline;
    end

    cft_field #(
        .MAX_FIELD_BYTES (MAX_FIELD_BYTES)
    ) u_field (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .text_byte (s1_byte_reg),
        .fs        (fs)
    );

    cft_pos #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_pos (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .pos   (pos)
    );

    // Build the result from the closing field
    always_comb
    begin
        numeric                = (fs.kind == KIND_INT) || (fs.kind == KIND_FLOAT);
        result.field_kind      = fs.kind;
        result.digit_value     = numeric ? fs.acc : '0;
        result.scale_digits    = (fs.kind == KIND_FLOAT) ? fs.frac : '0;
        result.value_saturated = numeric && fs.clamp;
        result.field_length    = fs.bytes;
        result.column_index    = pos.column;
        result.row_index       = pos.row;
        result.ends_row        = step.row_end;
        result.widest_row      = pos.widest_after;
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (step.close)
        begin
            out_valid_next = 1'b1;
        end
        else if (field_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture payloads
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_byte_reg <= text_in.text_byte;
            s1_eoi_reg  <= text_in.end_of_input;
        end
        if (step.close)
        begin
            out_reg <= result;
        end
    end

    assign field_out.valid           = out_valid_reg;
    assign field_out.field_kind      = out_reg.field_kind;
    assign field_out.digit_value     = out_reg.digit_value;
    assign field_out.scale_digits    = out_reg.scale_digits;
    assign field_out.value_saturated = out_reg.value_saturated;
    assign field_out.field_length    = out_reg.field_length;
    assign field_out.column_index    = out_reg.column_index;
    assign field_out.row_index       = out_reg.row_index;
    assign field_out.ends_row        = out_reg.ends_row;
    assign field_out.widest_row      = out_reg.widest_row;

endmodule

// ----- hw/rtl/cft_checker.sv -----
`include "assert_macros.svh"

module cft_checker import cft_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [1:0]         field_kind,
    input logic [VALUE_W-1:0] digit_value,
    input logic [LEN_W-1:0]   scale_digits,
    input logic               value_saturated,
    input logic [COL_W-1:0]   column_index,
    input logic               ends_row,
    input logic [WIDE_W-1:0]  widest_row
);

    // A stalled result keeps its place
    `CFT_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(digit_value))

    // Empty and string fields carry no numeric part
    `CFT_ASSERT_SAME(a_no_number, clk, rst_n, out_valid && (field_kind == KIND_EMPTY || field_kind == KIND_STRING), digit_value == '0 && scale_digits == '0 && !value_saturated)

    // A row-ending field makes the widest row at least as wide as its row
    `CFT_ASSERT_SAME(a_widest, clk, rst_n, out_valid && ends_row, widest_row > WIDE_W'(column_index))

    // A new result follows an accepted item
    `CFT_ASSERT_SAME(a_cause, clk, rst_n, $rose(out_valid), $past(in_valid && in_ready, 2))

endmodule

bind csv_field_typing_tokenizer cft_checker u_cft_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (text_in.valid),
    .in_ready        (text_in.ready),
    .out_valid       (field_out.valid),
    .out_ready       (field_out.ready),
    .field_kind      (field_out.field_kind),
    .digit_value     (field_out.digit_value),
    .scale_digits    (field_out.scale_digits),
    .value_saturated (field_out.value_saturated),
    .column_index    (field_out.column_index),
    .ends_row        (field_out.ends_row),
    .widest_row      (field_out.widest_row)
);
